/* src/mbrtu_pkg.sv */
// Shared types, constants and the CRC byte step for the Modbus RTU response receiver.
// No dependencies.
package mbrtu_pkg;

  localparam int MAX_FRAME = 64;
  localparam int IDX_W     = $clog2(MAX_FRAME);
  localparam int LEN_W     = 6;
  localparam int CMP_W     = (IDX_W > LEN_W) ? IDX_W : LEN_W;
  localparam int CFG_W     = 16;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_FRAME - 1);

  localparam logic [15:0]      CRC_POLY     = 16'hA001;
  localparam logic [15:0]      CRC_INIT     = 16'hFFFF;
  localparam logic [15:0]      FIX_RESET    = 16'd271;
  localparam logic [LEN_W-1:0] FIX_LEN      = LEN_W'(13);
  localparam logic [LEN_W-1:0] MIN_LEN      = LEN_W'(4);

  // request codes
  localparam logic [1:0] REQ_ARM  = 2'd0;
  localparam logic [1:0] REQ_BYTE = 2'd1;
  localparam logic [1:0] REQ_TMO  = 2'd2;

  // configuration register indexes
  localparam logic CFG_RETRY_LIMIT = 1'b0;
  localparam logic CFG_FIX_STATUS  = 1'b1;

  // captured frame bytes: tag id, status, x, y (big-endian), offsets 3..10
  localparam int               CAP_N     = 8;
  localparam logic [IDX_W-1:0] CAP_FIRST = IDX_W'(3);
  localparam logic [IDX_W-1:0] CAP_LAST  = IDX_W'(10);

  typedef struct packed {
    logic        done;
    logic        tmo;
    logic [15:0] crc;
    logic [7:0]  crc_hi;
    logic        fix;
    logic [1:0]  tag;
    logic [15:0] x;
    logic [15:0] y;
  } beat_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

/* src/mbrtu_in_if.sv */
// Input channel of the receiver: request beats.
// No dependencies.
interface mbrtu_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] rx_byte;
  logic [5:0] expected_length;

  modport source (output valid, req_type, rx_byte, expected_length, input ready);
  modport sink   (input valid, req_type, rx_byte, expected_length, output ready);
endinterface

/* src/mbrtu_out_if.sv */
// Result channel of the receiver: flags, retry count and tag coordinates.
// No dependencies.
interface mbrtu_out_if;
  logic               valid;
  logic               ready;
  logic               frame_done;
  logic               crc_ok;
  logic               position_updated;
  logic               link_error;
  logic [7:0]         retry_count;
  logic signed [15:0] tag0_x;
  logic signed [15:0] tag0_y;
  logic signed [15:0] tag1_x;
  logic signed [15:0] tag1_y;
  logic signed [15:0] tag2_x;
  logic signed [15:0] tag2_y;

  modport source (output valid, frame_done, crc_ok, position_updated, link_error,
                  retry_count, tag0_x, tag0_y, tag1_x, tag1_y, tag2_x, tag2_y,
                  input ready);
  modport sink   (input valid, frame_done, crc_ok, position_updated, link_error,
                  retry_count, tag0_x, tag0_y, tag1_x, tag1_y, tag2_x, tag2_y,
                  output ready);
endinterface

/* src/mbrtu_frame_rx.sv */
// Front stage: arming, frame store memory, running CRC and field capture.
// Depends on mbrtu_pkg and mbrtu_in_if.
module mbrtu_frame_rx (
  input  logic                clk,
  input  logic                rst_n,
  mbrtu_in_if.sink            in_ch,
  input  logic [15:0]         fix_status,
  input  logic                take,
  output logic                s1_valid,
  output mbrtu_pkg::beat_t    s1_beat,
  output logic [7:0]          rd_byte
);
  import mbrtu_pkg::*;

  logic [7:0]       mem [MAX_FRAME];

  logic             armed_r, armed_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic             s1_valid_r, s1_valid_nxt;
  beat_t            beat_r, beat_nxt;
  logic [7:0]       rd_r;
  logic [7:0]       cap_r [CAP_N];

  logic             accept;
  logic             we;
  logic             cap_we;
  logic [2:0]       cap_sel;
  logic [IDX_W-1:0] inc;
  logic [IDX_W-1:0] rd_addr;
  logic [CMP_W-1:0] len_ext;
  logic             tag_ok;

  assign in_ch.ready = !s1_valid_r || take;
  assign accept      = in_ch.valid && in_ch.ready;
  assign s1_valid    = s1_valid_r;
  assign s1_beat     = beat_r;
  assign rd_byte     = rd_r;

  assign len_ext = CMP_W'(len_r);
  assign inc     = idx_r + IDX_W'(1);
  assign rd_addr = (idx_r == '0) ? LAST_IDX : idx_r - IDX_W'(1);
  assign cap_sel = 3'(idx_r - CAP_FIRST);
  assign cap_we  = we && (idx_r >= CAP_FIRST) && (idx_r <= CAP_LAST);
  assign tag_ok  = (cap_r[0] == 8'h00) && (cap_r[1] <= 8'd2);

  always_comb begin
    armed_nxt    = armed_r;
    idx_nxt      = idx_r;
    len_nxt      = len_r;
    crc_nxt      = crc_r;
    s1_valid_nxt = s1_valid_r;
    beat_nxt     = beat_r;
    we           = 1'b0;
    if (take) begin
      s1_valid_nxt = 1'b0;
    end
    if (accept) begin
      s1_valid_nxt = 1'b1;
      beat_nxt     = '0;
      case (in_ch.req_type)
        REQ_ARM: begin
          len_nxt   = (in_ch.expected_length < MIN_LEN) ? MIN_LEN : in_ch.expected_length;
          idx_nxt   = '0;
          armed_nxt = 1'b1;
          crc_nxt   = CRC_INIT;
        end
        REQ_BYTE: begin
          if (armed_r) begin
            we = 1'b1;
            if (CMP_W'(idx_r) < len_ext - CMP_W'(2)) begin
              crc_nxt = crc16_byte(crc_r, in_ch.rx_byte);
            end
            idx_nxt = (inc == LAST_IDX) ? '0 : inc;
            if (CMP_W'(idx_nxt) >= len_ext) begin
              armed_nxt       = 1'b0;
              idx_nxt         = '0;
              beat_nxt.done   = 1'b1;
              beat_nxt.crc    = crc_r;
              beat_nxt.crc_hi = in_ch.rx_byte;
              beat_nxt.fix    = (len_r == FIX_LEN) && ({cap_r[2], cap_r[3]} == fix_status)
                                && tag_ok;
              beat_nxt.tag    = cap_r[1][1:0];
              beat_nxt.x      = {cap_r[4], cap_r[5]};
              beat_nxt.y      = {cap_r[6], cap_r[7]};
            end
          end
        end
        REQ_TMO: begin
          if (armed_r) begin
            armed_nxt    = 1'b0;
            beat_nxt.tmo = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r    <= 1'b0;
      idx_r      <= '0;
      len_r      <= '0;
      crc_r      <= CRC_INIT;
      s1_valid_r <= 1'b0;
    end else begin
      armed_r    <= armed_nxt;
      idx_r      <= idx_nxt;
      len_r      <= len_nxt;
      crc_r      <= crc_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    beat_r <= beat_nxt;
    if (cap_we) begin
      cap_r[cap_sel] <= in_ch.rx_byte;
    end
  end

  // frame store: one write, one registered read of the previous byte (CRC low)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[idx_r] <= in_ch.rx_byte;
    end
    if (accept) begin
      rd_r <= mem[rd_addr];
    end
  end

endmodule

/* src/mbrtu_result.sv */
// Result stage: CRC compare, retry counting, tag coordinate registers, output beat.
// Depends on mbrtu_pkg and mbrtu_out_if.
module mbrtu_result (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                s1_valid,
  input  mbrtu_pkg::beat_t    s1_beat,
  input  logic [7:0]          rd_byte,
  input  logic [7:0]          retry_limit,
  output logic                take,
  mbrtu_out_if.source         out_ch
);
  import mbrtu_pkg::*;

  logic        out_valid_r, out_valid_nxt;
  logic        done_r, done_nxt;
  logic        ok_r, ok_nxt;
  logic        upd_r, upd_nxt;
  logic        lerr_r, lerr_nxt;
  logic [7:0]  fc_r, fc_nxt;
  logic [15:0] tag_r [6];
  logic [15:0] tag_nxt [6];
  logic [7:0]  bumped;
  logic        crc_match;
  logic        bump;

  assign take      = s1_valid && (!out_valid_r || out_ch.ready);
  assign crc_match = s1_beat.crc == {s1_beat.crc_hi, rd_byte};
  assign bumped    = fc_r + 8'd1;
  assign bump      = s1_beat.tmo || (s1_beat.done && !crc_match);

  always_comb begin
    out_valid_nxt = out_valid_r;
    done_nxt      = done_r;
    ok_nxt        = ok_r;
    upd_nxt       = upd_r;
    lerr_nxt      = lerr_r;
    fc_nxt        = fc_r;
    tag_nxt       = tag_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (take) begin
      out_valid_nxt = 1'b1;
      done_nxt      = s1_beat.done;
      ok_nxt        = s1_beat.done && crc_match;
      upd_nxt       = s1_beat.done && crc_match && s1_beat.fix;
      lerr_nxt      = 1'b0;
      if (s1_beat.done && crc_match) begin
        fc_nxt = '0;
        if (s1_beat.fix) begin
          tag_nxt[{s1_beat.tag, 1'b0}] = s1_beat.x;
          tag_nxt[{s1_beat.tag, 1'b1}] = s1_beat.y;
        end
      end
      if (bump) begin
        if (retry_limit == '0) begin
          fc_nxt = '0;
        end else if (bumped >= retry_limit) begin
          fc_nxt   = '0;
          lerr_nxt = 1'b1;
        end else begin
          fc_nxt = bumped;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      fc_r        <= '0;
      for (int k = 0; k < 6; k++) begin
        tag_r[k] <= '0;
      end
    end else begin
      out_valid_r <= out_valid_nxt;
      fc_r        <= fc_nxt;
      tag_r       <= tag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    done_r <= done_nxt;
    ok_r   <= ok_nxt;
    upd_r  <= upd_nxt;
    lerr_r <= lerr_nxt;
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.frame_done       = done_r;
  assign out_ch.crc_ok           = ok_r;
  assign out_ch.position_updated = upd_r;
  assign out_ch.link_error       = lerr_r;
  assign out_ch.retry_count      = fc_r;
  assign out_ch.tag0_x           = tag_r[0];
  assign out_ch.tag0_y           = tag_r[1];
  assign out_ch.tag1_x           = tag_r[2];
  assign out_ch.tag1_y           = tag_r[3];
  assign out_ch.tag2_x           = tag_r[4];
  assign out_ch.tag2_y           = tag_r[5];

endmodule

/* src/modbus_rtu_position_response_rx.sv */
// Modbus RTU response receiver, top level. Beats pass s1, then the result register. One
// beat per cycle unless out_ch stalls, each with one frame-store read and at most one
// write. Reset (rst_n, synchronous, active low) clears control state, retry count and tag
// coordinates, and sets retry_limit to 0 and fix_status_word to 271; no clearing pass.
// Depends on mbrtu_pkg, mbrtu_in_if, mbrtu_out_if, mbrtu_frame_rx, mbrtu_result.
module modbus_rtu_position_response_rx (
  input  logic                    clk,
  input  logic                    rst_n,
  mbrtu_in_if.sink                in_ch,
  mbrtu_out_if.source             out_ch,
  input  logic                    cfg_we,
  input  logic                    cfg_idx,
  input  logic [mbrtu_pkg::CFG_W-1:0] cfg_wdata
);
  import mbrtu_pkg::*;

  logic [7:0]  retry_limit_r;
  logic [15:0] fix_status_r;
  logic        take;
  logic        s1_valid;
  beat_t       s1_beat;
  logic [7:0]  rd_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      retry_limit_r <= '0;
      fix_status_r  <= FIX_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_RETRY_LIMIT: retry_limit_r <= cfg_wdata[7:0];
        CFG_FIX_STATUS:  fix_status_r  <= cfg_wdata[15:0];
        default: begin
        end
      endcase
    end
  end

  mbrtu_frame_rx u_frame (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .fix_status (fix_status_r),
    .take       (take),
    .s1_valid   (s1_valid),
    .s1_beat    (s1_beat),
    .rd_byte    (rd_byte)
  );

  mbrtu_result u_result (
    .clk         (clk),
    .rst_n       (rst_n),
    .s1_valid    (s1_valid),
    .s1_beat     (s1_beat),
    .rd_byte     (rd_byte),
    .retry_limit (retry_limit_r),
    .take        (take),
    .out_ch      (out_ch)
  );

  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_ch.valid |-> in_ch.ready)
    else $error("input stalled with empty result register");

  a_flag_chain: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> ((!out_ch.crc_ok || out_ch.frame_done) &&
                      (!out_ch.position_updated || out_ch.crc_ok)))
    else $error("result flags inconsistent");

  a_link_error_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.link_error) |-> (out_ch.retry_count == 8'd0))
    else $error("link error without cleared retry count");

  a_ok_no_fail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.crc_ok) |-> (!out_ch.link_error && out_ch.retry_count == 8'd0))
    else $error("passing frame left a retry count");

endmodule

/* tb/tb_top.sv */
// Self-checking bench for modbus_rtu_position_response_rx: random request beats, one status
// beat predicted and checked per accepted request, config changed between phases.
// Depends on mbrtu_pkg, mbrtu_in_if, mbrtu_out_if and the receiver RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mbrtu_pkg::*;

  localparam logic [1:0] REQ_SPARE = 2'd3;

  typedef struct {
    logic [1:0] req;
    logic [7:0] data;
    logic [5:0] len;
  } request_t;

  typedef struct packed {
    logic             done;
    logic             ok;
    logic             upd;
    logic             lerr;
    logic [7:0]       retries;
    logic [5:0][15:0] coords;
  } status_t;

  typedef logic [7:0] octet_q_t[$];

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             req_valid = 1'b0;
  logic [1:0]       req_type = REQ_ARM;
  logic [7:0]       req_byte = 8'h00;
  logic [5:0]       req_len = 6'd0;
  logic             take_ready = 1'b0;
  logic             cfg_we = 1'b0;
  logic             cfg_idx = CFG_RETRY_LIMIT;
  logic [CFG_W-1:0] cfg_wdata = '0;

  mbrtu_in_if  in_if();
  mbrtu_out_if out_if();

  assign in_if.valid           = req_valid;
  assign in_if.req_type        = req_type;
  assign in_if.rx_byte         = req_byte;
  assign in_if.expected_length = req_len;
  assign out_if.ready          = take_ready;

  modbus_rtu_position_response_rx dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  request_t request_q[$];
  status_t  status_due_q[$];
  bit       in_taken = 1'b0;
  bit       hold_off = 1'b0;
  int       idle_pct = 0;
  int       stall_pct = 0;
  int       queued_n = 0;
  int       mismatches = 0;
  logic [15:0] gen_fix = FIX_RESET;

  // receiver state as the bench tracks it
  logic [7:0]       rx_store[MAX_FRAME];
  int               wr_pos = 0;
  bit               window_open = 1'b0;
  int               window_len = 0;
  logic [7:0]       fail_cnt = 8'd0;
  logic [5:0][15:0] coords = '0;
  logic [7:0]       retry_limit_cfg = 8'd0;
  logic [15:0]      fix_word_cfg = FIX_RESET;

  function automatic logic [15:0] modbus_crc(input logic [7:0] bytes[MAX_FRAME], input int n);
    logic [15:0] acc;
    acc = CRC_INIT;
    for (int i = 0; i < n; i++) begin
      acc ^= {8'h00, bytes[i]};
      repeat (8) acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
    end
    return acc;
  endfunction

  function automatic logic count_failure();
    fail_cnt = fail_cnt + 8'd1;
    if (retry_limit_cfg != 8'd0) begin
      if (fail_cnt >= retry_limit_cfg) begin
        fail_cnt = 8'd0;
        return 1'b1;
      end
      return 1'b0;
    end
    fail_cnt = 8'd0;
    return 1'b0;
  endfunction

  function automatic status_t predict_status(input request_t rq);
    status_t     st;
    logic [15:0] crc_calc;
    logic [15:0] crc_rx;
    int          tag;
    st = '0;
    if (rq.req == REQ_ARM) begin
      window_len  = (rq.len < MIN_LEN) ? int'(MIN_LEN) : int'(rq.len);
      wr_pos      = 0;
      window_open = 1'b1;
    end else if (rq.req == REQ_BYTE && window_open) begin
      rx_store[wr_pos] = rq.data;
      wr_pos = wr_pos + 1;
      if (wr_pos >= MAX_FRAME - 1) wr_pos = 0;
      if (wr_pos >= window_len) begin
        crc_calc    = modbus_crc(rx_store, window_len - 2);
        crc_rx      = {rx_store[window_len-1], rx_store[window_len-2]};
        st.done     = 1'b1;
        wr_pos      = 0;
        window_open = 1'b0;
        if (crc_calc == crc_rx) begin
          st.ok    = 1'b1;
          fail_cnt = 8'd0;
          if (window_len == FIX_LEN && {rx_store[5], rx_store[6]} == fix_word_cfg) begin
            tag = int'({rx_store[3], rx_store[4]});
            if (tag <= 2) begin
              coords[2*tag]   = {rx_store[7], rx_store[8]};
              coords[2*tag+1] = {rx_store[9], rx_store[10]};
              st.upd = 1'b1;
            end
          end
        end else begin
          st.lerr = count_failure();
        end
      end
    end else if (rq.req == REQ_TMO && window_open) begin
      window_open = 1'b0;
      st.lerr = count_failure();
    end
    st.retries = fail_cnt;
    st.coords  = coords;
    return st;
  endfunction

  task automatic flag_mismatch(input string what, input logic [15:0] got,
                               input logic [15:0] want);
    mismatches++;
    $display("%0t: %s got %h want %h", $time, what, got, want);
  endtask

  // request side: hold the beat until taken, else maybe offer the next one
  always @(negedge clk) begin : request_driver
    if (!rst_n) begin
      req_valid <= 1'b0;
    end else begin
      if (in_taken) request_q.delete(0);
      if (!(req_valid && !in_taken)) begin
        if (request_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          req_valid <= 1'b1;
          req_type  <= request_q[0].req;
          req_byte  <= request_q[0].data;
          req_len   <= request_q[0].len;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  always @(negedge clk) begin : result_pacing
    take_ready <= !hold_off && ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin : scoreboard
    status_t          want;
    logic [5:0][15:0] seen;
    request_t         rq;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (status_due_q.size() == 0) begin
          flag_mismatch("status beat with nothing pending", 16'h0, 16'h0);
        end else begin
          want = status_due_q.pop_front();
          seen = {out_if.tag2_y, out_if.tag2_x, out_if.tag1_y, out_if.tag1_x,
                  out_if.tag0_y, out_if.tag0_x};
          if (out_if.frame_done !== want.done)
            flag_mismatch("frame_done", 16'(out_if.frame_done), 16'(want.done));
          if (out_if.crc_ok !== want.ok)
            flag_mismatch("crc_ok", 16'(out_if.crc_ok), 16'(want.ok));
          if (out_if.position_updated !== want.upd)
            flag_mismatch("position_updated", 16'(out_if.position_updated), 16'(want.upd));
          if (out_if.link_error !== want.lerr)
            flag_mismatch("link_error", 16'(out_if.link_error), 16'(want.lerr));
          if (out_if.retry_count !== want.retries)
            flag_mismatch("retry_count", 16'(out_if.retry_count), 16'(want.retries));
          for (int k = 0; k < 6; k++) begin
            if (seen[k] !== want.coords[k])
              flag_mismatch($sformatf("tag%0d_%s", k / 2, (k % 2) ? "y" : "x"),
                            seen[k], want.coords[k]);
          end
        end
      end
      if (cfg_we) begin
        case (cfg_idx)
          CFG_RETRY_LIMIT: retry_limit_cfg = cfg_wdata[7:0];
          CFG_FIX_STATUS:  fix_word_cfg = cfg_wdata[15:0];
          default: ;
        endcase
      end
      if (in_if.valid && in_if.ready) begin
        rq.req  = in_if.req_type;
        rq.data = in_if.rx_byte;
        rq.len  = in_if.expected_length;
        status_due_q.push_back(predict_status(rq));
      end
      in_taken <= in_if.valid && in_if.ready;
    end
  end

  task automatic push_req(input logic [1:0] r, input logic [7:0] d, input logic [5:0] l);
    request_t t;
    t.req  = r;
    t.data = d;
    t.len  = l;
    request_q.push_back(t);
    queued_n++;
  endtask

  task automatic push_arm(input logic [5:0] l);
    push_req(REQ_ARM, 8'($urandom), l);
  endtask

  task automatic push_byte(input logic [7:0] b);
    push_req(REQ_BYTE, b, 6'($urandom));
  endtask

  task automatic push_tmo();
    push_req(REQ_TMO, 8'($urandom), 6'($urandom));
  endtask

  function automatic octet_q_t random_body(input int n);
    octet_q_t b;
    repeat (n) b.push_back(8'($urandom));
    return b;
  endfunction

  function automatic octet_q_t position_body(input logic [15:0] tag, input logic [15:0] status,
                                             input logic [15:0] x, input logic [15:0] y);
    octet_q_t b;
    b = random_body(3);
    b.push_back(tag[15:8]);
    b.push_back(tag[7:0]);
    b.push_back(status[15:8]);
    b.push_back(status[7:0]);
    b.push_back(x[15:8]);
    b.push_back(x[7:0]);
    b.push_back(y[15:8]);
    b.push_back(y[7:0]);
    return b;
  endfunction

  // appends the CRC, low byte first; a corrupt frame gets one bit flipped
  function automatic octet_q_t seal_frame(input octet_q_t body, input bit corrupt);
    logic [7:0]  fb[MAX_FRAME];
    logic [15:0] c;
    octet_q_t    f;
    int          p;
    f = body;
    foreach (body[i]) fb[i] = body[i];
    c = modbus_crc(fb, body.size());
    f.push_back(c[7:0]);
    f.push_back(c[15:8]);
    if (corrupt) begin
      p = $urandom_range(0, f.size() - 1);
      f[p] = f[p] ^ (8'd1 << $urandom_range(0, 7));
    end
    return f;
  endfunction

  task automatic queue_frame(input octet_q_t f);
    push_arm(6'(f.size()));
    foreach (f[i]) push_byte(f[i]);
  endtask

  function automatic logic [15:0] pick_tag();
    return ($urandom_range(0, 9) != 0) ? 16'($urandom_range(0, 2)) : 16'($urandom);
  endfunction

  task automatic queue_traffic(input int target, input int fail_pct);
    int       stop_at;
    int       n;
    octet_q_t body;
    stop_at = queued_n + target;
    while (queued_n < stop_at) begin
      if ($urandom_range(0, 99) < fail_pct) begin
        case ($urandom_range(0, 3))
          0: begin
            n = $urandom_range(4, 20);
            push_arm(6'(n));
            repeat ($urandom_range(0, n - 1)) push_byte(8'($urandom));
            push_tmo();
          end
          1: queue_frame(seal_frame(random_body($urandom_range(2, 18)), 1'b1));
          2: begin
            push_arm(6'($urandom_range(0, 3)));
            repeat (4) push_byte(8'($urandom));
          end
          default: begin
            push_arm(6'($urandom));
            push_tmo();
          end
        endcase
      end else begin
        n = $urandom_range(0, 9);
        if (n < 5) begin
          body = position_body(pick_tag(),
                               ($urandom_range(0, 5) != 0) ? gen_fix : 16'($urandom),
                               16'($urandom), 16'($urandom));
          queue_frame(seal_frame(body, 1'b0));
        end else if (n < 8) begin
          n = ($urandom_range(0, 7) == 0) ? $urandom_range(2, 60) : $urandom_range(2, 14);
          queue_frame(seal_frame(random_body(n), 1'b0));
        end else if (n == 8) begin
          // stray beats while idle, then a window abandoned by a re-arm
          repeat ($urandom_range(1, 3)) begin
            case ($urandom_range(0, 2))
              0:       push_byte(8'($urandom));
              1:       push_tmo();
              default: push_req(REQ_SPARE, 8'($urandom), 6'($urandom));
            endcase
          end
          push_arm(6'($urandom));
          repeat ($urandom_range(0, 2)) push_byte(8'($urandom));
          push_req(REQ_SPARE, 8'($urandom), 6'($urandom));
          queue_frame(seal_frame(random_body($urandom_range(2, 12)), 1'b0));
        end else if ($urandom_range(0, 3) == 0) begin
          // longest windows: the top length wraps and never completes
          push_arm(6'(MAX_FRAME - 1 - $urandom_range(0, 1)));
          repeat ($urandom_range(60, 130)) push_byte(8'($urandom));
          push_tmo();
        end else begin
          body = position_body(16'($urandom_range(0, 2)), gen_fix, 16'($urandom), 16'($urandom));
          repeat ($urandom_range(1, 3)) body.push_back(8'($urandom));
          queue_frame(seal_frame(body, 1'b0));
        end
      end
    end
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (request_q.size() != 0 || req_valid || status_due_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(input logic [7:0] lim, input logic [15:0] fix, input int idle,
                           input int stall, input bit squeeze, input int burst,
                           input int target, input int fail_pct);
    write_reg(CFG_RETRY_LIMIT, CFG_W'(lim));
    write_reg(CFG_FIX_STATUS, fix);
    gen_fix   = fix;
    idle_pct  = idle;
    stall_pct = stall;
    if (squeeze) begin
      fork
        begin
          hold_off = 1'b1;
          repeat (400) @(posedge clk);
          hold_off = 1'b0;
        end
      join_none
    end
    repeat (burst) begin
      push_arm(6'($urandom));
      push_tmo();
    end
    queue_traffic(target, fail_pct);
    drain();
  endtask

  initial begin : stimulus
    octet_q_t frame;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // idle noise, short-length saturation, a full-scale fix, a timeout
    push_byte(8'hFF);
    push_tmo();
    push_req(REQ_SPARE, 8'hFF, 6'h3F);
    frame = seal_frame('{8'h00, 8'hFF}, 1'b0);
    push_arm(6'd0);
    foreach (frame[i]) push_byte(frame[i]);
    queue_frame(seal_frame(position_body(16'd2, FIX_RESET, 16'h8000, 16'h7FFF), 1'b0));
    push_arm(6'd5);
    push_tmo();
    drain();

    run_phase(8'd3, FIX_RESET, 79, 0, 1'b0, 0, 350, 40);
    run_phase(8'd255, 16'h0000, 0, 79, 1'b0, 260, 60, 90);
    run_phase(8'd1, 16'hFFFF, 7, 7, 1'b0, 0, 350, 35);
    run_phase(8'd0, 16'($urandom), 0, 0, 1'b1, 0, 350, 30);
    run_phase(8'($urandom_range(2, 10)), FIX_RESET, 0, 79, 1'b0, 0, 300, 50);

    repeat (6) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #2ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule

/* filelist.f */
src/mbrtu_pkg.sv
src/mbrtu_in_if.sv
src/mbrtu_out_if.sv
src/mbrtu_frame_rx.sv
src/mbrtu_result.sv
src/modbus_rtu_position_response_rx.sv
tb/tb_top.sv
